// ===== src/kat_pkg.sv =====
`timescale 1ns / 1ps

package kat_pkg;

    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;

    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;
    localparam int SUM_W = 48;
    localparam int ALU_W = 50;

    localparam logic [OP_W-1:0] OP_SET = 2'd0;
    localparam logic [OP_W-1:0] OP_ACC = 2'd1;

    localparam logic signed [ALU_W-1:0] V32_MAX = {{(ALU_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [ALU_W-1:0] V32_MIN = {{(ALU_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    localparam logic signed [ALU_W-1:0] V48_MAX = {{(ALU_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [ALU_W-1:0] V48_MIN = {{(ALU_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        SAT_NONE,
        SAT_32,
        SAT_48
    } alu_mode_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_REM,
        ST_READ,
        ST_LOOK,
        ST_NEWV,
        ST_DELTA,
        ST_SUM,
        ST_FINISH
    } state_t;

endpackage

// ===== src/kat_alu.sv =====
`timescale 1ns / 1ps

// Shared adder with optional saturation to 32 or 48 bits.
module kat_alu import kat_pkg::*;
(
    input  logic signed [ALU_W-1:0] a,
    input  logic signed [ALU_W-1:0] b,
    input  alu_mode_t               mode,
    output logic signed [ALU_W-1:0] res
);

    logic signed [ALU_W-1:0] raw;

    assign raw = a + b;

    always_comb
    begin
        case (mode)
            SAT_32:
            begin
                if (raw > V32_MAX)
                    res = V32_MAX;
                else if (raw < V32_MIN)
                    res = V32_MIN;
                else
                    res = raw;
            end
            SAT_48:
            begin
                if (raw > V48_MAX)
                    res = V48_MAX;
                else if (raw < V48_MIN)
                    res = V48_MIN;
                else
                    res = raw;
            end
            default:
                res = raw;
        endcase
    end

endmodule

// ===== src/kat_mem.sv =====
`timescale 1ns / 1ps

// One bucket row per address, registered read.
module kat_mem import kat_pkg::*;
#(
    parameter int DEPTH  = BUCKETS_DEF,
    parameter int ADDR_W = 8,
    parameter int DATA_W = WAYS_DEF * $bits(slot_t)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/keyed_accumulate_table.sv =====
// Keyed accumulate table: key/value store with a saturating running sum.
// Input words (s_axis_*): tuser holds the operation (set, accumulate, get),
// tdata holds key and value. Every accepted word yields exactly one output
// word (m_axis_*): tuser holds found and table_full flags, tdata holds the
// stored value, the key count and the running sum after the request.
// The bucket is key mod BUCKETS; each bucket row holds WAYS slots, read through
// one memory port, compared in parallel and written back through the other. A
// new key whose bucket is full is dropped and flagged.
// Path from accept to output: a get or a dropped key passes READ, LOOK and
// FINISH; a stored set or accumulate passes READ, LOOK, NEWV, DELTA, SUM and
// FINISH. When BUCKETS is not a power of two, MOD and REM come first for the
// remainder (reciprocal multiply, then subtract on the shared adder). One
// request is worked at a time; tready is high only while idle. The finished
// word sits in an output register, so a new request is taken while it waits;
// a stalled receiver holds the next result back in its final step.
// After reset the block sweeps the table clear, one bucket row per cycle,
// with tready low.
`timescale 1ns / 1ps

module keyed_accumulate_table import kat_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // stored_value[31:0], entry_count[42:32],
                                        // total_sum[90:43], zero[95:91]
    output logic [1:0]  m_axis_tuser    // found[0], table_full[1]
);

    localparam int  IDX_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int  WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int  ROW_W    = WAYS * $bits(slot_t);
    localparam bit  BKT_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam logic [IDX_W-1:0] BKT_MASK = IDX_W'(BUCKETS - 1);
    localparam logic [IDX_W-1:0] BKT_LAST = IDX_W'(BUCKETS - 1);
    // ceil(2^(32+L) / BUCKETS) with L = ceil(log2 BUCKETS) gives an exact quotient
    localparam int  BKT_SH   = KEY_W + IDX_W;
    localparam logic [KEY_W:0] BKT_RECIP =
        (KEY_W+1)'(((64'd1 << BKT_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]        bkt_reg, bkt_next;
    logic [KEY_W-1:0]        quo_reg, quo_next;
    logic [IDX_W-1:0]        clr_reg, clr_next;
    logic                    hit_reg, hit_next;
    logic [WAY_W-1:0]        way_reg, way_next;
    logic signed [VAL_W-1:0] old_reg, old_next;
    logic signed [VAL_W-1:0] new_reg, new_next;
    logic signed [ALU_W-1:0] delta_reg, delta_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    res_found_reg, res_found_next;
    logic                    res_full_reg, res_full_next;
    logic signed [VAL_W-1:0] res_val_reg, res_val_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    out_found_reg, out_found_next;
    logic                    out_full_reg, out_full_next;
    logic signed [VAL_W-1:0] out_val_reg, out_val_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;
    logic signed [SUM_W-1:0] out_sum_reg, out_sum_next;

    logic                    mem_rd_en;
    logic                    mem_wr_en;
    logic [IDX_W-1:0]        mem_wr_addr;
    logic [ROW_W-1:0]        mem_wr_data;
    logic [ROW_W-1:0]        mem_rd_data;
    slot_t [WAYS-1:0]        row_rd;
    slot_t [WAYS-1:0]        row_wr;

    logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
    alu_mode_t               alu_mode;

    logic [2*KEY_W:0]        mod_prod;
    logic [KEY_W-1:0]        quo_mul;

    logic                    hit;
    logic [WAY_W-1:0]        hit_way;
    logic                    free;
    logic [WAY_W-1:0]        free_way;
    logic                    is_write;

    kat_mem #(
        .DEPTH  (BUCKETS),
        .ADDR_W (IDX_W),
        .DATA_W (ROW_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (bkt_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    kat_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .mode (alu_mode),
        .res  (alu_res)
    );

    assign row_rd   = mem_rd_data;
    assign is_write = (op_reg == OP_SET) || (op_reg == OP_ACC);

    assign mod_prod = (2*KEY_W+1)'(key_reg) * (2*KEY_W+1)'(BKT_RECIP);
    assign quo_mul  = quo_reg * KEY_W'(BUCKETS);

    // lowest matching way and lowest free way of the bucket row
    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_rd[w].valid)
            begin
                if (row_rd[w].key == key_reg)
                begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
            end
            else
            begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        row_wr               = row_rd;
        row_wr[way_reg]      = '{valid: 1'b1, key: key_reg, value: new_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        bkt_next       = bkt_reg;
        quo_next       = quo_reg;
        clr_next       = clr_reg;
        hit_next       = hit_reg;
        way_next       = way_reg;
        old_next       = old_reg;
        new_next       = new_reg;
        delta_next     = delta_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        res_found_next = res_found_reg;
        res_full_next  = res_full_reg;
        res_val_next   = res_val_reg;
        m_valid_next   = m_valid_reg;
        out_found_next = out_found_reg;
        out_full_next  = out_full_reg;
        out_val_next   = out_val_reg;
        out_cnt_next   = out_cnt_reg;
        out_sum_next   = out_sum_reg;
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = bkt_reg;
        mem_wr_data    = row_wr;
        alu_a          = '0;
        alu_b          = '0;
        alu_mode       = SAT_NONE;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == BKT_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next      = s_axis_tuser;
                    key_next     = s_axis_tdata[KEY_W-1:0];
                    val_next     = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
                    if (BKT_POW2)
                    begin
                        bkt_next   = s_axis_tdata[IDX_W-1:0] & BKT_MASK;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        bkt_next   = '0;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                // quotient by reciprocal multiply, exact for every 32-bit key
                quo_next   = KEY_W'(mod_prod >> BKT_SH);
                state_next = ST_REM;
            end
            ST_REM:
            begin
                alu_a      = ALU_W'(key_reg);
                alu_b      = ALU_W'(0) - ALU_W'(quo_mul);
                bkt_next   = alu_res[IDX_W-1:0];
                state_next = ST_READ;
            end
            ST_READ:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                hit_next       = hit;
                way_next       = hit ? hit_way : free_way;
                old_next       = hit ? row_rd[hit_way].value : '0;
                res_found_next = hit;
                res_full_next  = 1'b0;
                res_val_next   = '0;
                if (hit && !is_write)
                begin
                    res_val_next = row_rd[hit_way].value;
                    state_next   = ST_FINISH;
                end
                else if (is_write && (hit || free))
                    state_next = ST_NEWV;
                else
                begin
                    res_full_next = is_write;
                    state_next    = ST_FINISH;
                end
            end
            ST_NEWV:
            begin
                alu_a      = (op_reg == OP_ACC) ? ALU_W'(old_reg) : '0;
                alu_b      = ALU_W'(val_reg);
                alu_mode   = SAT_32;
                new_next   = alu_res[VAL_W-1:0];
                state_next = ST_DELTA;
            end
            ST_DELTA:
            begin
                alu_a      = ALU_W'(new_reg);
                alu_b      = ALU_W'(0) - ALU_W'(old_reg);
                delta_next = alu_res;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                alu_a        = ALU_W'(sum_reg);
                alu_b        = delta_reg;
                alu_mode     = SAT_48;
                sum_next     = alu_res[SUM_W-1:0];
                mem_wr_en    = 1'b1;
                res_val_next = new_reg;
                if (!hit_reg)
                    cnt_next = cnt_reg + 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next   = 1'b1;
                    out_found_next = res_found_reg;
                    out_full_next  = res_full_reg;
                    out_val_next   = res_val_reg;
                    out_cnt_next   = cnt_reg;
                    out_sum_next   = sum_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        bkt_reg       <= bkt_next;
        quo_reg       <= quo_next;
        hit_reg       <= hit_next;
        way_reg       <= way_next;
        old_reg       <= old_next;
        new_reg       <= new_next;
        delta_reg     <= delta_next;
        res_found_reg <= res_found_next;
        res_full_reg  <= res_full_next;
        res_val_reg   <= res_val_next;
        out_found_reg <= out_found_next;
        out_full_reg  <= out_full_next;
        out_val_reg   <= out_val_next;
        out_cnt_reg   <= out_cnt_next;
        out_sum_reg   <= out_sum_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, out_sum_reg, out_cnt_reg, out_val_reg};
    assign m_axis_tuser  = {out_full_reg, out_found_reg};

endmodule
